// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

// Implication with a fixed delay.
`define ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
		else $error("delayed implication failed");

`endif

// ===== hw/rtl/fsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Fresnel reflectance package
// Transfer types, pipeline depths and fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsr_pkg;

	localparam int FRONT_STAGES = 5;
	localparam int DIV_N_W      = 64;
	localparam int DIV_D_W      = 34;
	localparam int DIV_Q_W      = 33;
	localparam int DIV_STAGES   = DIV_Q_W;
	localparam int DIV_CMP_W    = DIV_N_W + 3;
	localparam int SQ_STAGES    = 17;
	localparam int SQ_REM_W     = 33;
	localparam int POLY_STAGES  = 6;
	localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 1 + SQ_STAGES + POLY_STAGES;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	typedef struct packed {
		logic signed [17:0] cos_incident;
		logic [15:0]        index_from;
		logic [15:0]        index_to;
	} item_t;

	typedef struct packed {
		logic [16:0] reflectance;
		logic        total_internal;
	} result_t;

	typedef struct packed {
		logic               tir;
		logic               n1gt;
		logic               n2zero;
		logic               szero;
		logic signed [17:0] c;
	} div_side_t;

	typedef struct packed {
		logic               tir;
		logic               n1gt;
		logic signed [17:0] c;
		logic [16:0]        r0;
	} sqrt_side_t;

endpackage

// ===== hw/rtl/schlick_fresnel_reflectance.sv =====
// ----------------------------------------------------------------------------
// Schlick Fresnel reflectance
// Fully pipelined fixed-point Fresnel reflectance with refraction and TIR.
// ----------------------------------------------------------------------------
// Usage: drive item with the incident cosine (Q1.16) and the two indices
// (Q4.12) and raise start; the transfer happens at any edge where start is
// high and busy is low. Busy is always low, so a new item may enter on every
// cycle and the sustained rate is one item per clock.
// Each result appears on result for exactly one cycle with done high,
// once its item has passed through every stage, in the order the items arrived.
// The path runs through five front stages, two parallel 33-stage restoring
// dividers, a radicand register, the 17-stage square root and six polynomial stages.
// The receiver cannot stall the block; it must take each result as shown.
// Reset clears every valid bit, so items in flight are dropped and no result
// strobe follows until new items are accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module schlick_fresnel_reflectance (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  fsr_pkg::item_t     item,
	output logic               done,
	output fsr_pkg::result_t   result
);

	logic                                front_valid;
	fsr_pkg::div_side_t                  front_side;
	logic [63:0]                         lhs;
	logic [31:0]                         n2sq, dsq;
	logic [33:0]                         ssq;
	logic                                div_valid;
	logic [fsr_pkg::DIV_Q_W-1:0]         sint_q, r0_q;
	fsr_pkg::div_side_t                  div_side;
	logic [fsr_pkg::DIV_Q_W-1:0]         sint_clamped;

	logic                                valid_s39;
	logic [fsr_pkg::SQ_REM_W-1:0]        radicand_s39;
	fsr_pkg::sqrt_side_t                 side_s39;

	logic                                sqrt_valid;
	logic [16:0]                         root;
	fsr_pkg::sqrt_side_t                 sqrt_side;

	assign busy = 1'b0;

	fsr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.item      (item),
		.out_valid (front_valid),
		.side      (front_side),
		.lhs       (lhs),
		.n2sq      (n2sq),
		.dsq       (dsq),
		.ssq       (ssq)
	);

	fsr_div u_div_sint (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.dividend  (lhs),
		.divisor   ({2'b00, n2sq}),
		.side_in   (front_side),
		.out_valid (div_valid),
		.quotient  (sint_q),
		.side_out  (div_side)
	);

	fsr_div u_div_r0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.dividend  ({16'd0, dsq, 16'd0}),
		.divisor   (ssq),
		.side_in   (front_side),
		.out_valid (),
		.quotient  (r0_q),
		.side_out  ()
	);

	assign sint_clamped = div_side.n2zero ? '0
	                    : (sint_q > fsr_pkg::ONE_Q32) ? fsr_pkg::ONE_Q32 : sint_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s39 <= 1'b0;
		end else begin
			valid_s39 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		radicand_s39  <= fsr_pkg::ONE_Q32 - sint_clamped;
		side_s39.tir  <= div_side.tir;
		side_s39.n1gt <= div_side.n1gt;
		side_s39.c    <= div_side.c;
		side_s39.r0   <= div_side.szero ? 17'd0 : r0_q[16:0];
	end

	fsr_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s39),
		.radicand  (radicand_s39),
		.side_in   (side_s39),
		.out_valid (sqrt_valid),
		.root      (root),
		.side_out  (sqrt_side)
	);

	fsr_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sqrt_valid),
		.root     (root),
		.side     (sqrt_side),
		.done     (done),
		.result   (result)
	);

endmodule

// ===== hw/rtl/fsr_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Index products, squared cosine and the total internal reflection test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  fsr_pkg::item_t      item,
	output logic                out_valid,
	output fsr_pkg::div_side_t  side,
	output logic [63:0]         lhs,
	output logic [31:0]         n2sq,
	output logic [31:0]         dsq,
	output logic [33:0]         ssq
);

	logic [4:0]          valid_s;
	logic signed [35:0]  csq_full;

	logic signed [17:0]  c_s1, c_s2, c_s3, c_s4, c_s5;
	logic                n1gt_s1, n1gt_s2, n1gt_s3, n1gt_s4, n1gt_s5;
	logic [15:0]         n1_s1, n2_s1, d_s1;
	logic [16:0]         s_s1;
	logic [34:0]         csq_s1;
	logic [31:0]         n1sq_s2, n1sq_s3;
	logic [31:0]         n2sq_s2, n2sq_s3, n2sq_s4, n2sq_s5;
	logic [31:0]         dsq_s2, dsq_s3, dsq_s4, dsq_s5;
	logic [33:0]         ssq_s2, ssq_s3, ssq_s4, ssq_s5;
	logic [31:0]         csq_s2;
	logic                small_s2, small_s3;
	logic                n2zero_s2, n2zero_s3, n2zero_s4, n2zero_s5;
	logic                szero_s2, szero_s3, szero_s4, szero_s5;
	logic [63:0]         prod_s3, lhs_s4, lhs_s5;
	logic                tir_s5;

	assign csq_full = item.cos_incident * item.cos_incident;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		c_s1    <= item.cos_incident;
		n1gt_s1 <= item.index_from > item.index_to;
		n1_s1   <= item.index_from;
		n2_s1   <= item.index_to;
		d_s1    <= (item.index_from > item.index_to) ? item.index_from - item.index_to
		                                             : item.index_to - item.index_from;
		s_s1    <= {1'b0, item.index_from} + {1'b0, item.index_to};
		csq_s1  <= csq_full[34:0];

		c_s2      <= c_s1;
		n1gt_s2   <= n1gt_s1;
		n1sq_s2   <= n1_s1 * n1_s1;
		n2sq_s2   <= n2_s1 * n2_s1;
		dsq_s2    <= d_s1 * d_s1;
		ssq_s2    <= s_s1 * s_s1;
		csq_s2    <= csq_s1[31:0];
		small_s2  <= csq_s1[34:32] == 3'd0;
		n2zero_s2 <= n2_s1 == 16'd0;
		szero_s2  <= s_s1 == 17'd0;

		c_s3      <= c_s2;
		n1gt_s3   <= n1gt_s2;
		n1sq_s3   <= n1sq_s2;
		n2sq_s3   <= n2sq_s2;
		dsq_s3    <= dsq_s2;
		ssq_s3    <= ssq_s2;
		small_s3  <= small_s2;
		n2zero_s3 <= n2zero_s2;
		szero_s3  <= szero_s2;
		prod_s3   <= n1sq_s2 * csq_s2;

		c_s4      <= c_s3;
		n1gt_s4   <= n1gt_s3;
		n2sq_s4   <= n2sq_s3;
		dsq_s4    <= dsq_s3;
		ssq_s4    <= ssq_s3;
		n2zero_s4 <= n2zero_s3;
		szero_s4  <= szero_s3;
		lhs_s4    <= small_s3 ? ({n1sq_s3, 32'd0} - prod_s3) : 64'd0;

		c_s5      <= c_s4;
		n1gt_s5   <= n1gt_s4;
		n2sq_s5   <= n2sq_s4;
		dsq_s5    <= dsq_s4;
		ssq_s5    <= ssq_s4;
		n2zero_s5 <= n2zero_s4;
		szero_s5  <= szero_s4;
		lhs_s5    <= lhs_s4;
		tir_s5    <= n1gt_s4 && (lhs_s4 > {n2sq_s4, 32'd0});
	end

	assign out_valid   = valid_s[4];
	assign side.tir    = tir_s5;
	assign side.n1gt   = n1gt_s5;
	assign side.n2zero = n2zero_s5;
	assign side.szero  = szero_s5;
	assign side.c      = c_s5;
	assign lhs         = lhs_s5;
	assign n2sq        = n2sq_s5;
	assign dsq         = dsq_s5;
	assign ssq         = ssq_s5;

endmodule

// ===== hw/rtl/fsr_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsr_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [fsr_pkg::DIV_N_W-1:0]     dividend,
	input  logic [fsr_pkg::DIV_D_W-1:0]     divisor,
	input  fsr_pkg::div_side_t              side_in,
	output logic                            out_valid,
	output logic [fsr_pkg::DIV_Q_W-1:0]     quotient,
	output fsr_pkg::div_side_t              side_out
);

	logic                            valid_s [fsr_pkg::DIV_STAGES];
	logic [fsr_pkg::DIV_N_W-1:0]     rem_s   [fsr_pkg::DIV_STAGES];
	logic [fsr_pkg::DIV_D_W-1:0]     den_s   [fsr_pkg::DIV_STAGES];
	logic [fsr_pkg::DIV_Q_W-1:0]     quo_s   [fsr_pkg::DIV_STAGES];
	fsr_pkg::div_side_t              side_s  [fsr_pkg::DIV_STAGES];

	for (genvar k = 0; k < fsr_pkg::DIV_STAGES; k++) begin : g_stage
		logic                            v_in;
		logic [fsr_pkg::DIV_N_W-1:0]     r_in;
		logic [fsr_pkg::DIV_D_W-1:0]     d_in;
		logic [fsr_pkg::DIV_Q_W-1:0]     q_in;
		fsr_pkg::div_side_t              sd_in;
		logic [fsr_pkg::DIV_CMP_W-1:0]   shifted;
		logic                            ge;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign r_in  = dividend;
			assign d_in  = divisor;
			assign q_in  = '0;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = valid_s[k-1];
			assign r_in  = rem_s[k-1];
			assign d_in  = den_s[k-1];
			assign q_in  = quo_s[k-1];
			assign sd_in = side_s[k-1];
		end

		assign shifted = {{(fsr_pkg::DIV_CMP_W - fsr_pkg::DIV_D_W){1'b0}}, d_in}
		                 << (fsr_pkg::DIV_Q_W - 1 - k);
		assign ge = {{(fsr_pkg::DIV_CMP_W - fsr_pkg::DIV_N_W){1'b0}}, r_in} >= shifted;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? r_in - shifted[fsr_pkg::DIV_N_W-1:0] : r_in;
			den_s[k]  <= d_in;
			quo_s[k]  <= {q_in[fsr_pkg::DIV_Q_W-2:0], ge};
			side_s[k] <= sd_in;
		end
	end

	assign out_valid = valid_s[fsr_pkg::DIV_STAGES-1];
	assign quotient  = quo_s[fsr_pkg::DIV_STAGES-1];
	assign side_out  = side_s[fsr_pkg::DIV_STAGES-1];

endmodule

// ===== hw/rtl/fsr_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined square root
// Digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsr_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [fsr_pkg::SQ_REM_W-1:0]  radicand,
	input  fsr_pkg::sqrt_side_t           side_in,
	output logic                          out_valid,
	output logic [16:0]                   root,
	output fsr_pkg::sqrt_side_t           side_out
);

	logic                          valid_s [fsr_pkg::SQ_STAGES];
	logic [fsr_pkg::SQ_REM_W-1:0]  rem_s   [fsr_pkg::SQ_STAGES];
	logic [fsr_pkg::SQ_REM_W-1:0]  root_s  [fsr_pkg::SQ_STAGES];
	fsr_pkg::sqrt_side_t           side_s  [fsr_pkg::SQ_STAGES];

	for (genvar k = 0; k < fsr_pkg::SQ_STAGES; k++) begin : g_stage
		localparam logic [fsr_pkg::SQ_REM_W-1:0] BIT =
			{{(fsr_pkg::SQ_REM_W-1){1'b0}}, 1'b1} << (2 * (fsr_pkg::SQ_STAGES - 1 - k));

		logic                          v_in;
		logic [fsr_pkg::SQ_REM_W-1:0]  x_in;
		logic [fsr_pkg::SQ_REM_W-1:0]  r_in;
		fsr_pkg::sqrt_side_t           sd_in;
		logic [fsr_pkg::SQ_REM_W:0]    trial;
		logic                          ge;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign x_in  = radicand;
			assign r_in  = '0;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = valid_s[k-1];
			assign x_in  = rem_s[k-1];
			assign r_in  = root_s[k-1];
			assign sd_in = side_s[k-1];
		end

		assign trial = {1'b0, r_in} + {1'b0, BIT};
		assign ge    = {1'b0, x_in} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? x_in - trial[fsr_pkg::SQ_REM_W-1:0] : x_in;
			root_s[k] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
			side_s[k] <= sd_in;
		end
	end

	assign out_valid = valid_s[fsr_pkg::SQ_STAGES-1];
	assign root      = root_s[fsr_pkg::SQ_STAGES-1][16:0];
	assign side_out  = side_s[fsr_pkg::SQ_STAGES-1];

endmodule

// ===== hw/rtl/fsr_poly.sv =====
// ----------------------------------------------------------------------------
// Schlick polynomial
// Fifth power of one minus the cosine, blend with R0, saturation and the TIR override.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsr_poly (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [16:0]          root,
	input  fsr_pkg::sqrt_side_t  side,
	output logic                 done,
	output fsr_pkg::result_t     result
);

	logic [5:0]          valid_s;
	logic signed [18:0]  c19, ceff, f19;
	logic [35:0]         f2_full;
	logic [39:0]         f4_full;
	logic [41:0]         f5_full;
	logic [27:0]         sum;

	logic [17:0]         f_s1, f_s2, f_s3;
	logic [19:0]         f2_s2;
	logic [23:0]         f4_s3;
	logic [25:0]         f5_s4;
	logic [42:0]         prod_s5;
	logic [16:0]         r0_s1, r0_s2, r0_s3, r0_s4, r0_s5;
	logic                tir_s1, tir_s2, tir_s3, tir_s4, tir_s5;
	fsr_pkg::result_t    result_s6;

	assign c19  = {side.c[17], side.c};
	assign ceff = side.n1gt ? $signed({2'b00, root})
	            : (c19 > $signed({2'b00, fsr_pkg::ONE_Q16})) ? $signed({2'b00, fsr_pkg::ONE_Q16})
	            : c19;
	assign f19  = $signed({2'b00, fsr_pkg::ONE_Q16}) - ceff;

	assign f2_full = f_s1 * f_s1;
	assign f4_full = f2_s2 * f2_s2;
	assign f5_full = f4_s3 * f_s3;
	assign sum     = {11'd0, r0_s5} + {1'b0, prod_s5[42:16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[4:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		f_s1   <= f19[17:0];
		r0_s1  <= side.r0;
		tir_s1 <= side.tir;

		f_s2   <= f_s1;
		f2_s2  <= f2_full[35:16];
		r0_s2  <= r0_s1;
		tir_s2 <= tir_s1;

		f_s3   <= f_s2;
		f4_s3  <= f4_full[39:16];
		r0_s3  <= r0_s2;
		tir_s3 <= tir_s2;

		f5_s4  <= f5_full[41:16];
		r0_s4  <= r0_s3;
		tir_s4 <= tir_s3;

		prod_s5 <= (fsr_pkg::ONE_Q16 - r0_s4) * f5_s4;
		r0_s5   <= r0_s4;
		tir_s5  <= tir_s4;

		if (tir_s5) begin
			result_s6.reflectance <= fsr_pkg::ONE_Q16;
		end else if (sum > {11'd0, fsr_pkg::ONE_Q16}) begin
			result_s6.reflectance <= fsr_pkg::ONE_Q16;
		end else begin
			result_s6.reflectance <= sum[16:0];
		end
		result_s6.total_internal <= tir_s5;
	end

	assign done   = valid_s[5];
	assign result = result_s6;

endmodule

// ===== hw/rtl/fsr_checker.sv =====
// ----------------------------------------------------------------------------
// Fresnel reflectance checker
// Port-level latency, origin, total internal reflection and range checks, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsr_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  fsr_pkg::item_t     item,
	input  logic               done,
	input  fsr_pkg::result_t   result
);

	logic item_seen;

	assign item_seen = item.index_from != 16'd0 || item.index_to != 16'd0 || 1'b1;

	`ASSERT_DELAY(a_latency, clk, arst_n, start && !busy && item_seen, fsr_pkg::LATENCY, done)
	`ASSERT_IMPLY(a_origin, clk, arst_n, done, $past(start && !busy, fsr_pkg::LATENCY))
	`ASSERT_IMPLY(a_tir_one, clk, arst_n, done && result.total_internal, result.reflectance == fsr_pkg::ONE_Q16)
	`ASSERT_ALWAYS(a_range, clk, arst_n, !done || result.reflectance <= fsr_pkg::ONE_Q16)

endmodule

bind schlick_fresnel_reflectance fsr_checker u_checker (.*);

// ===== tb/sv/tb_schlick_fresnel_reflectance.sv =====
// ----------------------------------------------------------------------------
// Schlick Fresnel reflectance testbench
// Drives incident cosines and index pairs into the pipeline, predicts each
// reflectance and total internal reflection flag in exact integer arithmetic,
// and compares every result strobe against the oldest prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_schlick_fresnel_reflectance;

	class fresnel_scoreboard;
		fsr_pkg::result_t pending[$];
		int errors = 0;

		function automatic logic [63:0] root_floor(logic [63:0] x);
			logic [63:0] r;
			logic [63:0] b;
			r = 64'd0;
			b = 64'h1_0000_0000;
			while (b > x && b != 0)
				b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function automatic fsr_pkg::result_t reflectance_of(fsr_pkg::item_t it);
			fsr_pkg::result_t o;
			longint c;
			logic [63:0] n1, n2, d, s, r0, csq, s2, lhs, rhs, sint2, f, f2, f4, f5, sum;
			c = longint'(it.cos_incident);
			n1 = 64'(it.index_from);
			n2 = 64'(it.index_to);
			d = (n1 > n2) ? n1 - n2 : n2 - n1;
			s = n1 + n2;
			r0 = 64'd0;
			if (s != 0)
				r0 = ((d * d) << 16) / (s * s);
			if (n1 > n2) begin
				csq = c * c;
				s2 = (csq < 64'h1_0000_0000) ? 64'h1_0000_0000 - csq : 64'd0;
				lhs = n1 * n1 * s2;
				rhs = (n2 * n2) << 32;
				if (lhs > rhs) begin
					o.reflectance = fsr_pkg::ONE_Q16;
					o.total_internal = 1'b1;
					return o;
				end
				sint2 = (n2 != 0) ? lhs / (n2 * n2) : 64'd0;
				if (sint2 > 64'h1_0000_0000)
					sint2 = 64'h1_0000_0000;
				c = longint'(root_floor(64'h1_0000_0000 - sint2));
			end
			if (c > 65536)
				c = 65536;
			f = 65536 - c;
			f2 = (f * f) >> 16;
			f4 = (f2 * f2) >> 16;
			f5 = (f4 * f) >> 16;
			sum = r0 + (((65536 - r0) * f5) >> 16);
			if (sum > 65536)
				sum = 64'd65536;
			o.reflectance = sum[16:0];
			o.total_internal = 1'b0;
			return o;
		endfunction

		function void note_item(fsr_pkg::item_t it);
			pending.push_back(reflectance_of(it));
		endfunction

		function void check_result(fsr_pkg::result_t got);
			fsr_pkg::result_t want;
			if (pending.size() == 0) begin
				$error("result with no transfer pending: reflectance %0d", got.reflectance);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.reflectance !== want.reflectance) begin
				$error("reflectance expected %0d actual %0d", want.reflectance, got.reflectance);
				errors++;
			end
			if (got.total_internal !== want.total_internal) begin
				$error("total_internal expected %0d actual %0d", want.total_internal,
					got.total_internal);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	fsr_pkg::item_t item;
	logic done;
	fsr_pkg::result_t result;
	fresnel_scoreboard board;
	int cycles = 0;
	bit no_gaps = 0;

	schlick_fresnel_reflectance uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			board.check_result(result);

	task automatic send_item(fsr_pkg::item_t it);
		while (!no_gaps && $urandom_range(99) < 30) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_item(it);
	endtask

	task automatic idle_input();
		start <= 1'b0;
	endtask

	function automatic fsr_pkg::item_t make_item(int c, int n1, int n2);
		fsr_pkg::item_t it;
		it.cos_incident = 18'(c);
		it.index_from = 16'(n1);
		it.index_to = 16'(n2);
		return it;
	endfunction

	function automatic int rand_cos();
		case ($urandom_range(5))
			0: return $urandom_range(131071) - 65536;
			1: return $urandom_range(262143) - 131072;
			default: return $urandom_range(65536);
		endcase
	endfunction

	function automatic int rand_index();
		case ($urandom_range(3))
			0: return $urandom_range(65535, 1);
			default: return $urandom_range(8192, 4096);
		endcase
	endfunction

	initial begin
		int n1;
		board = new();
		arst_n = 0;
		start = 0;
		item = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(make_item(65536, 4096, 6144));
		send_item(make_item(0, 4096, 6144));
		send_item(make_item(-65536, 4096, 6144));
		send_item(make_item(-131072, 65535, 1));
		send_item(make_item(131071, 1, 65535));
		send_item(make_item(131071, 4096, 4096));
		send_item(make_item(32768, 6144, 4096));
		send_item(make_item(65536, 6144, 4096));
		send_item(make_item(0, 6144, 4096));
		send_item(make_item(-131072, 6144, 4096));
		send_item(make_item(65536, 65535, 1));
		send_item(make_item(-65536, 65535, 65534));
		send_item(make_item(-1, 1, 1));
		send_item(make_item(60000, 5000, 4096));
		send_item(make_item(-20000, 4096, 65535));
		send_item(make_item(43690, 21845, 43690));

		idle_input();
		while (board.pending.size() != 0)
			@(posedge clk);

		for (int k = 0; k < 1050; k++) begin
			no_gaps = (k >= 300 && k < 450);
			if ($urandom_range(3) == 0) begin
				n1 = rand_index();
				send_item(make_item(rand_cos(), n1, n1));
			end else begin
				send_item(make_item(rand_cos(), rand_index(), rand_index()));
			end
			if (k == 600) begin
				idle_input();
				while (board.pending.size() != 0)
					@(posedge clk);
			end
		end

		idle_input();
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (fsr_pkg::LATENCY + 10) @(posedge clk);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
